### sv/word_rle_encoder_assert.svh
// Assertion macros for the word run-length encoder checker.
// No dependencies; included by wre_checker.sv.
`ifndef WORD_RLE_ENCODER_ASSERT_SVH
`define WORD_RLE_ENCODER_ASSERT_SVH

// same-cycle implication, off during reset
`define WRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define WRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked across reset
`define WRE_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/wre_pkg.sv
// Shared types and constants of the word run-length encoder.
// No dependencies; imported by every module of the block but wre_ram.
`timescale 1ns / 1ps

package wre_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 6;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] word_value;
        logic              buffer_end;
    } t_in_item;

    typedef struct packed {
        logic              is_header;
        logic [DATA_W-1:0] out_value;
        logic              last;
    } t_out_item;

    // one packet to emit: a run (header + word) or literals (header + window)
    typedef struct packed {
        logic              lits;
        logic [CNT_W-1:0]  cnt;
        logic [DATA_W-1:0] word;
    } t_job;

endpackage

### sv/wre_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/wre_front.sv
// Front end: accepts items, tracks run/literal counts, writes the literal window
// and issues packet jobs. Depends on wre_pkg.
`timescale 1ns / 1ps

module wre_front
    import wre_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  t_in_item                  i_item,
    input  logic                      i_q_full,
    output logic                      o_q_push,
    output t_job                      o_q_job,
    input  logic                      i_lits_done,
    output logic                      o_ram_we,
    output logic [$clog2(WINDOW)-1:0] o_ram_waddr,
    output logic [DATA_W-1:0]         o_ram_wdata
);

    localparam int ADDR_W = $clog2(WINDOW);
    localparam logic [CNT_W-1:0] CUT = CNT_W'(WINDOW - 1);

    logic [CNT_W-1:0]  r_run, n_run;
    logic [CNT_W-1:0]  r_lit, n_lit;
    logic [DATA_W-1:0] r_run_word, n_run_word;
    logic [DATA_W-1:0] r_last_lit, n_last_lit;
    logic              r_lit_pend, n_lit_pend;
    logic              accept;
    logic [CNT_W-1:0]  run_inc, lit_inc, lit_dec;
    logic [DATA_W-1:0] w;

    assign o_full  = i_q_full | r_lit_pend;
    assign accept  = i_push & ~o_full;
    assign w       = i_item.word_value;
    assign run_inc = CNT_W'(r_run + 1'b1);
    assign lit_inc = CNT_W'(r_lit + 1'b1);
    assign lit_dec = CNT_W'(r_lit - 1'b1);

    always_comb begin
        n_run       = r_run;
        n_lit       = r_lit;
        n_run_word  = r_run_word;
        n_last_lit  = r_last_lit;
        n_lit_pend  = r_lit_pend & ~i_lits_done;
        o_q_push    = 1'b0;
        o_q_job     = '{lits: 1'b0, cnt: r_run, word: r_run_word};
        o_ram_we    = 1'b0;
        o_ram_waddr = '0;
        o_ram_wdata = w;
        if (accept) begin
            if (i_item.op == OP_FLUSH) begin
                if (r_run != '0) begin
                    o_q_push = 1'b1;
                end else if (r_lit != '0) begin
                    o_q_push    = 1'b1;
                    o_q_job     = '{lits: 1'b1, cnt: r_lit, word: r_run_word};
                    n_lit_pend  = 1'b1;
                end
                n_run = '0;
                n_lit = '0;
            end else if (r_run != '0) begin
                if (r_run_word == w) begin
                    n_run = run_inc;
                    if (run_inc == CUT) begin
                        o_q_push = 1'b1;
                        o_q_job  = '{lits: 1'b0, cnt: run_inc, word: r_run_word};
                        n_run    = '0;
                    end
                end else begin
                    o_q_push   = 1'b1;
                    n_run      = '0;
                    n_lit      = CNT_W'(1);
                    n_last_lit = w;
                    o_ram_we   = 1'b1;
                end
            end else if (r_lit != '0) begin
                if (r_last_lit == w) begin
                    if (lit_dec != '0) begin
                        o_q_push   = 1'b1;
                        o_q_job    = '{lits: 1'b1, cnt: lit_dec, word: r_run_word};
                        n_lit_pend = 1'b1;
                    end
                    n_lit      = '0;
                    n_run      = CNT_W'(2);
                    n_run_word = w;
                end else begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_lit[ADDR_W-1:0];
                    n_lit       = lit_inc;
                    n_last_lit  = w;
                    if (lit_inc == CUT) begin
                        o_q_push   = 1'b1;
                        o_q_job    = '{lits: 1'b1, cnt: lit_inc, word: r_run_word};
                        n_lit_pend = 1'b1;
                        n_lit      = '0;
                    end
                end
            end else begin
                o_ram_we   = 1'b1;
                n_lit      = CNT_W'(1);
                n_last_lit = w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= '0;
            r_lit      <= '0;
            r_lit_pend <= 1'b0;
        end else begin
            r_run      <= n_run;
            r_lit      <= n_lit;
            r_lit_pend <= n_lit_pend;
        end
        r_run_word <= n_run_word;
        r_last_lit <= n_last_lit;
    end

endmodule

### sv/wre_queue.sv
// Two-entry job queue between front and back end.
// Depends on wre_pkg.
`timescale 1ns / 1ps

module wre_queue
    import wre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wptr = r_wptr ^ do_push;
        n_rptr = r_rptr ^ do_pop;
        n_cnt  = 2'(r_cnt + {1'b0, do_push} - {1'b0, do_pop});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

### sv/wre_back.sv
// Back end: turns jobs into header and data results, reading literals
// from the window RAM. Depends on wre_pkg.
`timescale 1ns / 1ps

module wre_back
    import wre_pkg::*;
#(
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_job              i_q_job,
    output logic              o_q_pop,
    output logic              o_ram_re,
    output logic [ADDR_W-1:0] o_ram_raddr,
    input  logic [DATA_W-1:0] i_ram_rdata,
    output logic              o_lits_done,
    output logic              o_empty,
    input  logic              i_pop,
    output t_out_item         o_item
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WORD  = 4'b0010,
        S_LREQ  = 4'b0100,
        S_LDATA = 4'b1000
    } t_bstate;

    t_bstate          r_state, n_state;
    t_job             r_job, n_job;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_out_v, n_out_v;
    t_out_item        r_out, n_out;
    logic             out_free;
    logic             lit_last;

    assign out_free    = ~r_out_v | i_pop;
    assign lit_last    = (r_idx == CNT_W'(r_job.cnt - 1'b1));
    assign o_ram_raddr = r_idx[ADDR_W-1:0];
    assign o_empty     = ~r_out_v;
    assign o_item      = r_out;

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_v     = r_out_v & ~i_pop;
        o_q_pop     = 1'b0;
        o_ram_re    = 1'b0;
        o_lits_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    n_job   = i_q_job;
                    n_idx   = '0;
                    n_out   = '{is_header: 1'b1,
                                out_value: {{(DATA_W-CNT_W-1){1'b0}}, i_q_job.cnt,
                                            ~i_q_job.lits},
                                last: 1'b0};
                    n_out_v = 1'b1;
                    n_state = i_q_job.lits ? S_LREQ : S_WORD;
                end
            end
            S_WORD: begin
                if (out_free) begin
                    n_out   = '{is_header: 1'b0, out_value: r_job.word, last: 1'b1};
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_LREQ: begin
                if (out_free) begin
                    o_ram_re = 1'b1;
                    n_state  = S_LDATA;
                end
            end
            S_LDATA: begin
                // output slot is free here: only this state fills it after LREQ
                n_out   = '{is_header: 1'b0, out_value: i_ram_rdata, last: lit_last};
                n_out_v = 1'b1;
                n_idx   = CNT_W'(r_idx + 1'b1);
                if (lit_last) begin
                    o_lits_done = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_LREQ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
        end
        r_job <= n_job;
        r_idx <= n_idx;
        r_out <= n_out;
    end

endmodule

### sv/word_rle_encoder.sv
// Top level of the word run-length encoder: front end, job queue, back end
// and literal window RAM. Depends on wre_pkg, wre_ram, wre_front, wre_queue, wre_back.
//
// Input channel: i_in_item is taken on a clock edge with push high and full low.
//   op = flush drains what is pending; buffer_end is carried but ignored.
// Result channel: the oldest result sits on o_out_item while empty is low and
//   leaves on an edge with pop high. A packet is a header (is_header = 1,
//   count*2+1 for a run, count*2 for literals) followed by its data words;
//   last marks the final result of the item that caused it.
// Throughput: items that cause no packet are taken back to back while full is low.
//   A packet leaves as one result per cycle for the header and a run word while pop
//   keeps the output free; each literal goes through a request state and a data state,
//   as the read of the window RAM in the back end is registered. With the back end
//   idle, a job is registered in the queue and then its header in the output register.
// The front end may run up to two packets ahead of the back end; it holds full
//   high while a literal packet is still being read out of the window.
// Reset (synchronous, i_rst_n low) clears counts, queue and output; the window
//   holds no valid data until literals are written. A stalled receiver freezes
//   the output register, and full rises once the queue fills up.
`timescale 1ns / 1ps

module word_rle_encoder
    import wre_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    localparam int ADDR_W = $clog2(WINDOW);

    logic              q_push, q_full, q_valid, q_pop;
    t_job              q_in_job, q_out_job;
    logic              lits_done;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    wre_front #(.WINDOW(WINDOW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_in_item),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (q_in_job),
        .i_lits_done (lits_done),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    wre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_out_job),
        .i_pop   (q_pop)
    );

    wre_ram #(.WIDTH(DATA_W), .DEPTH(WINDOW)) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    wre_back #(.ADDR_W(ADDR_W)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (q_out_job),
        .o_q_pop     (q_pop),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_lits_done (lits_done),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_out_item)
    );

endmodule

### sv/wre_checker.sv
// Port-level assertions for the word run-length encoder, bound to the top level.
// Depends on wre_pkg and word_rle_encoder_assert.svh.
`timescale 1ns / 1ps
`include "word_rle_encoder_assert.svh"

module wre_checker
    import wre_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_out_item
);

    logic stall;
    logic hdr_seen;
    logic hdr_ok;
    logic word_mid;

    assign stall    = !empty && !pop;
    assign hdr_seen = !empty && o_out_item.is_header;
    assign hdr_ok   = !o_out_item.last && (o_out_item.out_value[DATA_W-1:16] == '0)
                      && (o_out_item.out_value != '0);
    assign word_mid = !empty && pop && !o_out_item.is_header && !o_out_item.last;

    `WRE_ASSERT_ALWAYS(a_reset_clear, !i_rst_n, empty && !full, "reset left block busy")

    `WRE_ASSERT_NEXT(a_out_hold, stall, !empty && $stable(o_out_item), "stalled item changed")

    `WRE_ASSERT_NOW(a_header_form, hdr_seen, hdr_ok, "malformed header")

    `WRE_ASSERT_NEXT(a_body_order, word_mid, !hdr_seen, "header inside packet body")

endmodule

bind word_rle_encoder wre_checker u_chk (.*);

### tb/word_rle_encoder_test.sv
// Self-checking testbench for word_rle_encoder: a built-in run-length predictor
// is fed by the accepted items, and its packets are compared with the outputs.
// Depends on wre_pkg and word_rle_encoder.
`timescale 1ns / 1ps

module word_rle_encoder_test;
    import wre_pkg::*;

    localparam int WIN        = 32;
    localparam int WIN_AW     = $clog2(WIN);
    localparam int CYCLE_CAP  = 400000;
    localparam int DRAIN_TAIL = 12;
    localparam int HOLD_LEN   = 400;

    typedef enum int {BURST_RUN, BURST_LITERAL, BURST_POOL, BURST_FLUSH} burst_kind_e;

    logic      i_clk;
    logic      i_rst_n   = 1'b0;
    logic      push      = 1'b0;
    logic      pop       = 1'b0;
    t_in_item  i_in_item = '0;
    logic      full;
    logic      empty;
    t_out_item o_out_item;

    // encoder state as predicted from accepted items
    int unsigned run_cnt;
    int unsigned lit_cnt;
    logic [DATA_W-1:0] lit_win [WIN];
    t_out_item step_words[$];
    t_out_item expected_stream[$];

    int err_cnt       = 0;
    int cycle_cnt     = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left     = 0;

    word_rle_encoder #(.WINDOW(WIN)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_item  (i_in_item),
        .empty      (empty),
        .pop        (pop),
        .o_out_item (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void emit_word(logic hdr, logic [DATA_W-1:0] v);
        t_out_item r;
        r.is_header = hdr;
        r.out_value = v;
        r.last      = 1'b0;
        step_words.push_back(r);
    endfunction

    function automatic void emit_packets();
        if (run_cnt != 0) begin
            emit_word(1'b1, ((run_cnt << 1) + 1) & 32'h0000_FFFF);
            emit_word(1'b0, lit_win[0]);
            run_cnt = 0;
        end
        if (lit_cnt != 0) begin
            emit_word(1'b1, (lit_cnt << 1) & 32'h0000_FFFF);
            for (int i = 0; i < lit_cnt; i++)
                emit_word(1'b0, lit_win[WIN_AW'(i)]);
            lit_cnt = 0;
        end
    endfunction

    function automatic void rle_predict(t_in_item it);
        logic [DATA_W-1:0] w;
        w = it.word_value;
        step_words.delete();
        if (it.op == OP_FLUSH) begin
            emit_packets();
        end else begin
            if (run_cnt != 0) begin
                if (lit_win[0] == w) begin
                    run_cnt++;
                end else begin
                    emit_packets();
                    lit_win[0] = w;
                    lit_cnt    = 1;
                end
            end else if (lit_cnt != 0) begin
                if (lit_win[WIN_AW'((lit_cnt - 1) % WIN)] == w) begin
                    lit_cnt--;
                    emit_packets();
                    lit_win[0] = w;
                    run_cnt    = 2;
                end else begin
                    lit_win[WIN_AW'(lit_cnt % WIN)] = w;
                    lit_cnt++;
                end
            end else begin
                lit_win[0] = w;
                lit_cnt    = 1;
            end
            if (run_cnt + 1 >= WIN)
                emit_packets();
            if (lit_cnt + 1 >= WIN)
                emit_packets();
        end
        if (step_words.size() != 0)
            step_words[step_words.size() - 1].last = 1'b1;
        foreach (step_words[i])
            expected_stream.push_back(step_words[i]);
    endfunction

    function automatic void check_result(t_out_item got);
        t_out_item want;
        if (expected_stream.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, got);
            err_cnt++;
        end else begin
            want = expected_stream.pop_front();
            if (got.is_header !== want.is_header) begin
                $display("%0t: is_header expected %0b actual %0b",
                         $time, want.is_header, got.is_header);
                err_cnt++;
            end
            if (got.out_value !== want.out_value) begin
                $display("%0t: out_value expected %08h actual %08h",
                         $time, want.out_value, got.out_value);
                err_cnt++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0b actual %0b",
                         $time, want.last, got.last);
                err_cnt++;
            end
        end
    endfunction

    // input and output handshakes seen at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full)
                rle_predict(i_in_item);
            if (pop && !empty)
                check_result(o_out_item);
        end
    end

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_in_item mk_item(logic op, logic [DATA_W-1:0] w, logic be);
        t_in_item it;
        it.op         = op;
        it.word_value = w;
        it.buffer_end = be;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
    endtask

    task automatic send_word(input logic [DATA_W-1:0] w);
        send_item(mk_item(OP_ENCODE, w, 1'($urandom_range(1))));
    endtask

    task automatic send_flush();
        send_item(mk_item(OP_FLUSH, $urandom, 1'($urandom_range(1))));
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_stream.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // bursts of runs, fresh literals and words from a small pool, mixed with flushes
    task automatic send_random_items(input int count);
        int sent;
        int len;
        burst_kind_e kind;
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] pool [4];
        sent = 0;
        while (sent < count) begin
            kind = burst_kind_e'($urandom_range(3));
            len  = $urandom_range(1, 12);
            if ($urandom_range(7) == 0)
                len = $urandom_range(25, 36);
            w = $urandom;
            foreach (pool[i])
                pool[i] = $urandom;
            if (kind == BURST_FLUSH) begin
                send_flush();
                sent++;
            end else begin
                for (int k = 0; k < len && sent < count; k++) begin
                    if (kind == BURST_LITERAL)
                        w = $urandom;
                    else if (kind == BURST_POOL)
                        w = pool[2'($urandom_range(3))];
                    if (kind == BURST_RUN && $urandom_range(19) == 0)
                        send_word($urandom);
                    else
                        send_word(w);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        send_item(mk_item(OP_FLUSH, 32'hFFFF_FFFF, 1'b1));
        send_item(mk_item(OP_ENCODE, 32'h0000_0000, 1'b0));
        send_item(mk_item(OP_ENCODE, 32'hFFFF_FFFF, 1'b1));
        send_item(mk_item(OP_FLUSH, 32'h0000_0000, 1'b0));
        // run grows from a repeated literal, then a new word breaks it
        repeat (4) send_item(mk_item(OP_ENCODE, 32'h1234_5678, 1'b0));
        send_item(mk_item(OP_ENCODE, 32'h9ABC_DEF0, 1'b1));
        send_item(mk_item(OP_FLUSH, 32'h5555_5555, 1'b0));
        // literal block cut by a repeat of its last word
        send_item(mk_item(OP_ENCODE, 32'hAAAA_0001, 1'b1));
        send_item(mk_item(OP_ENCODE, 32'hAAAA_0002, 1'b0));
        send_item(mk_item(OP_ENCODE, 32'hAAAA_0002, 1'b1));
        send_item(mk_item(OP_ENCODE, 32'h8000_0000, 1'b0));
        send_item(mk_item(OP_ENCODE, 32'h8000_0000, 1'b1));
        send_item(mk_item(OP_ENCODE, 32'h0000_0001, 1'b0));
        send_item(mk_item(OP_FLUSH, 32'hAAAA_AAAA, 1'b1));
        send_item(mk_item(OP_FLUSH, 32'h0000_0000, 1'b0));
        wait_drain();
    endtask

    // runs and literal blocks long enough to hit the window cut
    task automatic test_long_packets();
        logic [DATA_W-1:0] w;
        set_idling(0, 0);
        w = $urandom;
        repeat ($urandom_range(WIN - 1, WIN + 4)) send_word(w);
        send_flush();
        repeat ($urandom_range(WIN - 1, WIN + 2)) send_word($urandom);
        send_flush();
        wait_drain();
    endtask

    task automatic test_no_idle();
        set_idling(0, 0);
        send_random_items(56);
        wait_drain();
    endtask

    task automatic test_sender_idle();
        set_idling(59, 0);
        send_random_items(56);
        wait_drain();
    endtask

    task automatic test_receiver_stall();
        set_idling(0, 59);
        send_random_items(56);
        wait_drain();
    endtask

    task automatic test_both_idle();
        set_idling(32, 32);
        send_random_items(56);
        wait_drain();
    endtask

    // receiver holds off while the sender keeps offering; full must rise
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_left <= HOLD_LEN;
        repeat (40) send_word($urandom);
        send_flush();
        wait_drain();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_long_packets();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();
        if (err_cnt == 0 && expected_stream.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
